// ----- src/gpbms_pkg.sv -----
// gpbms_pkg: shared widths, constants, register indexes and the lane control word
// for the grid path budget max score block; no dependencies
package gpbms_pkg;

   // fixed field and register widths
   localparam int CELL_W      = 8;
   localparam int SCORE_OUT_W = 13;
   localparam int NUM_ROWS_W  = 11;
   localparam int NUM_COLS_W  = 9;
   localparam int BUDGET_W    = 5;
   localparam int ROW_W       = 10;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 11;

   // score saturation and row limit
   localparam int SAT_W      = 12;
   localparam int SCORE_SAT  = 4095;
   localparam int ROW_LIMIT  = 1024;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ROWS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_COLS    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COST_BUDGET = 2'd2;

   // per-cell control shared by all lanes
   typedef struct packed {
      logic first;
      logic has_up;
      logic has_left;
      logic nz;
   } gpbms_ctl_type;

endpackage

// ----- src/gpbms_lane.sv -----
// gpbms_lane: next score and valid mark of one budget level for the current cell
// depends on gpbms_pkg
module gpbms_lane #(
   parameter int LEVEL      = 0,
   parameter int VALUE_BITS = 8,
   parameter int SCORE_W    = 12,
   parameter int LEVEL_W    = 5
) (
   input  gpbms_pkg::gpbms_ctl_type ctl,
   input  logic [VALUE_BITS-1:0]    cell_val,
   input  logic [LEVEL_W-1:0]       budget,
   input  logic [SCORE_W:0]         up_cur,
   input  logic [SCORE_W:0]         up_prev,
   input  logic [SCORE_W:0]         left_cur,
   input  logic [SCORE_W:0]         left_prev,
   output logic                     nxt_valid,
   output logic [SCORE_W-1:0]       nxt_score
);

   logic [SCORE_W:0]   src_up;
   logic [SCORE_W:0]   src_left;
   logic               uv;
   logic               lv;
   logic [SCORE_W-1:0] best;
   logic [SCORE_W:0]   sum;
   logic [SCORE_W-1:0] sat;
   logic               in_budget;
   logic               v;

   always_comb begin
      // a nonzero cell draws from one level lower
      src_up   = ctl.nz ? up_prev : up_cur;
      src_left = ctl.nz ? left_prev : left_cur;
      uv       = ctl.has_up && src_up[SCORE_W];
      lv       = ctl.has_left && src_left[SCORE_W];
      best     = uv ? src_up[SCORE_W-1:0] : '0;
      if (lv && (!uv || (src_left[SCORE_W-1:0] > best))) begin
         best = src_left[SCORE_W-1:0];
      end
      sum = {1'b0, best} + (SCORE_W+1)'(cell_val);
      sat = (sum > (SCORE_W+1)'(gpbms_pkg::SCORE_SAT)) ? SCORE_W'(gpbms_pkg::SCORE_SAT)
                                                        : sum[SCORE_W-1:0];
      in_budget = LEVEL_W'(LEVEL) <= budget;
      if (ctl.first) begin
         v         = ctl.nz ? (LEVEL == 1) : (LEVEL == 0);
         nxt_score = SCORE_W'(cell_val);
      end else begin
         v         = !(ctl.nz && (LEVEL == 0)) && (uv || lv);
         nxt_score = sat;
      end
      nxt_valid = v && in_budget;
   end

endmodule

// ----- src/gpbms_max_tree.sv -----
// gpbms_max_tree: balanced compare tree picking the best valid score over all levels,
// -1 when none is valid; depends on gpbms_pkg
module gpbms_max_tree #(
   parameter int LEVELS  = 17,
   parameter int SCORE_W = 12
) (
   input  logic [LEVELS-1:0]                       lvl_valid,
   input  logic [LEVELS-1:0][SCORE_W-1:0]          lvl_score,
   output logic signed [gpbms_pkg::SCORE_OUT_W-1:0] best_score
);

   localparam int NP = 1 << $clog2(LEVELS);

   logic [2*NP-2:0]    node_v;
   logic [SCORE_W-1:0] node_s [2*NP-1];
   logic [SCORE_W+gpbms_pkg::SCORE_OUT_W-1:0] root_ext;

   for (genvar j = 0; j < NP; j++) begin : g_leaf
      if (j < LEVELS) begin : g_used
         assign node_v[NP-1+j] = lvl_valid[j];
         assign node_s[NP-1+j] = lvl_score[j];
      end else begin : g_pad
         assign node_v[NP-1+j] = 1'b0;
         assign node_s[NP-1+j] = '0;
      end
   end

   for (genvar i = 0; i < NP-1; i++) begin : g_node
      logic pick_r;
      assign pick_r    = node_v[2*i+2] && (!node_v[2*i+1] || (node_s[2*i+2] > node_s[2*i+1]));
      assign node_v[i] = node_v[2*i+1] || node_v[2*i+2];
      assign node_s[i] = pick_r ? node_s[2*i+2] : node_s[2*i+1];
   end

   assign root_ext   = {{gpbms_pkg::SCORE_OUT_W{1'b0}}, node_s[0]};
   assign best_score = node_v[0] ? root_ext[gpbms_pkg::SCORE_OUT_W-1:0]
                                 : {gpbms_pkg::SCORE_OUT_W{1'b1}};

endmodule

// ----- src/grid_path_budget_max_score_top.sv -----
// grid_path_budget_max_score_top: best monotone grid path score under a cost budget
// depends on gpbms_pkg, gpbms_lane, gpbms_max_tree
//
// usage:
//   set num_rows, num_cols and cost_budget on the csr port while idle, then stream
//   the grid cells row-major on req_ (one word per cell). one rsp_ word comes out
//   for the last cell of each grid: the best score over all budget levels, or -1.
// timing:
//   a cell word is taken every cycle while req_ready is high. the result for the last
//   cell passes stage a (row memory read and position decode), stage b (the level
//   lanes), then the compare tree into the output register. the row memory has one
//   write and one read port, and the previous cell's levels are forwarded, so
//   one-column grids also run at full rate.
// stall:
//   while a result waits on rsp_ready, non-final cells keep flowing; req_ready
//   drops only when the next final cell sits in stage b and the output is full and not taken.
// reset:
//   clears the position counters, pipeline valids and output valid, and sets
//   num_rows=1, num_cols=1, cost_budget=0. row memory needs no clearing, as the
//   first row ignores what it reads.
module grid_path_budget_max_score_top #(
   parameter int MAX_COLS   = 256,
   parameter int MAX_BUDGET = 16,
   parameter int VALUE_BITS = 8
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [gpbms_pkg::CELL_W-1:0]              req_cell_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [gpbms_pkg::SCORE_OUT_W-1:0]  rsp_best_score,
   input  logic                                      csr_wr_en,
   input  logic [gpbms_pkg::CSR_ADDR_W-1:0]          csr_addr,
   input  logic [gpbms_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int LV  = MAX_BUDGET + 1;
   localparam int LW  = (MAX_BUDGET > 0) ? $clog2(MAX_BUDGET + 1) : 1;
   localparam int BCW = (LW > gpbms_pkg::BUDGET_W) ? LW : gpbms_pkg::BUDGET_W;
   localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int EW  = ($clog2(MAX_COLS + 1) > gpbms_pkg::NUM_COLS_W) ?
                        $clog2(MAX_COLS + 1) : gpbms_pkg::NUM_COLS_W;
   localparam int SCW = (VALUE_BITS > gpbms_pkg::SAT_W) ? VALUE_BITS : gpbms_pkg::SAT_W;
   localparam int RW  = gpbms_pkg::NUM_ROWS_W;

   // configuration
   logic [RW-1:0]                    num_rows_ff;
   logic [gpbms_pkg::NUM_COLS_W-1:0] num_cols_ff;
   logic [gpbms_pkg::BUDGET_W-1:0]   budget_ff;
   logic [RW-1:0]                    rows_eff;
   logic [EW-1:0]                    cols_eff;
   logic [LW-1:0]                    budget_eff;

   // position
   logic [gpbms_pkg::ROW_W-1:0] row_ff;
   logic [gpbms_pkg::ROW_W-1:0] row_in;
   logic [CW-1:0]               col_ff;
   logic [CW-1:0]               col_in;
   logic [CW-1:0]               rd_col;
   logic                        last_col;
   logic                        last_row;
   logic [VALUE_BITS-1:0]       cell_val;
   logic                        acc;
   logic                        adv;

   // pipeline
   logic                      a_valid_ff;
   logic                      a_last_ff;
   gpbms_pkg::gpbms_ctl_type  a_ctl_ff;
   gpbms_pkg::gpbms_ctl_type  a_ctl_in;
   logic [VALUE_BITS-1:0]     a_val_ff;
   logic [CW-1:0]             a_col_ff;
   logic                      byp_ff;
   logic [LV-1:0][SCW:0]      mem_rd_ff;
   logic [LV-1:0][SCW:0]      row_mem [MAX_COLS];
   logic [LV-1:0][SCW:0]      up_word;
   logic [LV-1:0][SCW:0]      ns_word;
   logic [LV-1:0]             ns_valid;
   logic [LV-1:0][SCW-1:0]    ns_score;
   logic                      b_valid_ff;
   logic                      b_last_ff;
   logic [LV-1:0][SCW:0]      b_ns_ff;
   logic [LV-1:0]             b_valid_vec;
   logic [LV-1:0][SCW-1:0]    b_score_vec;
   logic signed [gpbms_pkg::SCORE_OUT_W-1:0] tree_best;
   logic                      rsp_valid_ff;
   logic signed [gpbms_pkg::SCORE_OUT_W-1:0] rsp_score_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= RW'(1);
         num_cols_ff <= gpbms_pkg::NUM_COLS_W'(1);
         budget_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            gpbms_pkg::CSR_NUM_ROWS:    num_rows_ff <= csr_wdata[RW-1:0];
            gpbms_pkg::CSR_NUM_COLS:    num_cols_ff <= csr_wdata[gpbms_pkg::NUM_COLS_W-1:0];
            gpbms_pkg::CSR_COST_BUDGET: budget_ff   <= csr_wdata[gpbms_pkg::BUDGET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (num_rows_ff == '0) begin
         rows_eff = RW'(1);
      end else if (num_rows_ff > RW'(gpbms_pkg::ROW_LIMIT)) begin
         rows_eff = RW'(gpbms_pkg::ROW_LIMIT);
      end else begin
         rows_eff = num_rows_ff;
      end
      if (num_cols_ff == '0) begin
         cols_eff = EW'(1);
      end else if (EW'(num_cols_ff) > EW'(MAX_COLS)) begin
         cols_eff = EW'(MAX_COLS);
      end else begin
         cols_eff = EW'(num_cols_ff);
      end
      budget_eff = (BCW'(budget_ff) > BCW'(MAX_BUDGET)) ? LW'(MAX_BUDGET) : LW'(budget_ff);
   end

   // ---------------- position decode ----------------
   assign adv       = !(b_valid_ff && b_last_ff) || !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign acc       = req_valid && adv;
   assign cell_val  = VALUE_BITS'(req_cell_value);

   always_comb begin
      rd_col   = (EW'(col_ff) < cols_eff) ? col_ff : CW'(cols_eff - EW'(1));
      last_col = (EW'(col_ff) + EW'(1)) >= cols_eff;
      last_row = (RW'(row_ff) + RW'(1)) >= rows_eff;
      a_ctl_in.has_up   = row_ff != '0;
      a_ctl_in.has_left = col_ff != '0;
      a_ctl_in.first    = (row_ff == '0) && (col_ff == '0);
      a_ctl_in.nz       = cell_val != '0;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + gpbms_pkg::ROW_W'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (acc) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- stage a: cell register and row memory read ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_last_ff <= last_col && last_row;
         a_ctl_ff  <= a_ctl_in;
         a_val_ff  <= cell_val;
         a_col_ff  <= rd_col;
         // the cell in stage a writes this column at the same edge
         byp_ff    <= a_valid_ff && (a_col_ff == rd_col);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && a_valid_ff) begin
         row_mem[a_col_ff] <= ns_word;
      end
      if (adv) begin
         mem_rd_ff <= row_mem[rd_col];
      end
   end

   // ---------------- level lanes ----------------
   assign up_word = byp_ff ? b_ns_ff : mem_rd_ff;

   for (genvar l = 0; l < LV; l++) begin : g_lane
      logic [SCW:0] up_prev;
      logic [SCW:0] left_prev;
      if (l == 0) begin : g_base
         assign up_prev   = '0;
         assign left_prev = '0;
      end else begin : g_upper
         assign up_prev   = up_word[l-1];
         assign left_prev = b_ns_ff[l-1];
      end
      gpbms_lane #(
         .LEVEL      (l),
         .VALUE_BITS (VALUE_BITS),
         .SCORE_W    (SCW),
         .LEVEL_W    (LW)
      ) u_lane (
         .ctl       (a_ctl_ff),
         .cell_val  (a_val_ff),
         .budget    (budget_eff),
         .up_cur    (up_word[l]),
         .up_prev   (up_prev),
         .left_cur  (b_ns_ff[l]),
         .left_prev (left_prev),
         .nxt_valid (ns_valid[l]),
         .nxt_score (ns_score[l])
      );
      assign ns_word[l]     = {ns_valid[l], ns_score[l]};
      assign b_valid_vec[l] = b_ns_ff[l][SCW];
      assign b_score_vec[l] = b_ns_ff[l][SCW-1:0];
   end

   // ---------------- stage b: level results, also the left neighbor ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && a_valid_ff) begin
         b_last_ff <= a_last_ff;
         b_ns_ff   <= ns_word;
      end
   end

   gpbms_max_tree #(
      .LEVELS  (LV),
      .SCORE_W (SCW)
   ) u_max_tree (
      .lvl_valid  (b_valid_vec),
      .lvl_score  (b_score_vec),
      .best_score (tree_best)
   );

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && b_valid_ff && b_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && b_valid_ff && b_last_ff) begin
         rsp_score_ff <= tree_best;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_score = rsp_score_ff;

`ifndef SYNTHESIS
   // input stalls only behind a waiting result with a final cell queued
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && b_valid_ff && b_last_ff))
      else $error("input stalled without a waiting result");

   // a new result only comes from a final cell in stage b
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(b_valid_ff && b_last_ff))
      else $error("result without a final cell");

   // pipeline is empty right after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (!a_valid_ff && !b_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
